// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the allocator modules. Each use expects
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NFPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NFPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types and fixed field widths of the page window allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int SIZE_W    = 23;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 2;

  localparam logic ACT_MAP   = 1'b0;
  localparam logic ACT_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_NO_RUN     = 2'd1,
    RES_OUTSIDE    = 2'd2,
    RES_NOT_MAPPED = 2'd3
  } res_code_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MARK,
    S_ULOOK,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      scan_init;
    logic      scan_run;
    logic      retry;
    logic      map_take;
    logic      unmap_take;
    logic      mark_step;
    logic      clr_step;
    logic      set_code;
    res_code_t code;
    logic      res_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_unmap;
    logic outside;
    logic found;
    logic exhausted;
    logic retried;
    logic mark_last;
    logic len_zero;
    logic clr_last;
  } dp_sts_t;

endpackage

// ----- sv/nfpa_req_if.sv -----
// ----------------------------------------------------------------------------
// nfpa_req_if
// Request channel: map or unmap command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nfpa_req_if;
  import nfpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] unmap_address;

  modport source (output valid, output action, output size_bytes, output unmap_address,
                  input ready);
  modport sink   (input valid, input action, input size_bytes, input unmap_address,
                  output ready);
endinterface

// ----- sv/nfpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// nfpa_rsp_if
// Response channel: status, mapped address and flush flag.
// ----------------------------------------------------------------------------
interface nfpa_rsp_if;
  import nfpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   map_address;
  logic                flush_all;

  modport source (output valid, output status, output map_address, output flush_all,
                  input ready);
  modport sink   (input valid, input status, input map_address, input flush_all,
                  output ready);
endinterface

// ----- sv/next_fit_page_window_allocator.sv -----
// ----------------------------------------------------------------------------
// next_fit_page_window_allocator
// Next-fit allocator of contiguous page runs inside a virtual window.
//   in_req  : one beat per request; action 0 maps size_bytes (rounded up to
//             whole pages), action 1 frees the run starting at the page that
//             holds unmap_address.
//   out_rsp : one beat per request with status, map_address, flush_all.
//   cfg_we/cfg_wdata : write window_base while the block is idle.
// Reset clears window_base and the finger, then runs a clearing pass over every
// page of both page memories; in_req.ready stays low meanwhile.
// PAGE_BYTES is a power of two, so bytes turn into pages by a shift.
// One request at a time: accept and decode, then for a map a scan for a free
// run (at most two search passes through the single read port of the presence
// memory) and the marking of the pages found; an unmap does a lookup of the
// run length and then frees its pages; an unmap address outside the window
// skips both; then the result is loaded. A finished beat waits in the output
// register; the next request is accepted meanwhile, and its result waits if
// out_rsp is still stalled.
// ----------------------------------------------------------------------------
module next_fit_page_window_allocator #(
  parameter int WINDOW_PAGES = 1024,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nfpa_req_if.sink                    in_req,
  nfpa_rsp_if.source                  out_rsp,
  input  logic                        cfg_we,
  input  logic [nfpa_pkg::ADDR_W-1:0] cfg_wdata
);
  import nfpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns both handshakes
  nfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: page shift, page memories, counters, result registers
  nfpa_dp #(
    .WINDOW_PAGES (WINDOW_PAGES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_req.action),
    .in_size_bytes    (in_req.size_bytes),
    .in_unmap_address (in_req.unmap_address),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_rsp.status),
    .out_map_address  (out_rsp.map_address),
    .out_flush_all    (out_rsp.flush_all)
  );

endmodule

// ----- sv/nfpa_dp.sv -----
// ----------------------------------------------------------------------------
// nfpa_dp
// Datapath: page-size shift, presence and run-length memories, scan and mark
// counters, result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfpa_dp #(
  parameter int WINDOW_PAGES = 1024,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nfpa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                          in_action,
  input  logic [nfpa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [nfpa_pkg::ADDR_W-1:0]   in_unmap_address,
  input  nfpa_pkg::dp_cmd_t             cmd,
  output nfpa_pkg::dp_sts_t             sts,
  output logic [nfpa_pkg::STATUS_W-1:0] out_status,
  output logic [nfpa_pkg::ADDR_W-1:0]   out_map_address,
  output logic                          out_flush_all
);
  import nfpa_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW_PAGES);
  localparam int FNG_W  = $clog2(WINDOW_PAGES + 1);
  localparam int PCNT_W = $clog2(WINDOW_PAGES + 2);
  localparam int PB_W   = $clog2(PAGE_BYTES + 1);
  localparam int PB_SH  = $clog2(PAGE_BYTES);
  localparam longint unsigned SPAN_L = longint'(WINDOW_PAGES) * longint'(PAGE_BYTES);
  localparam logic [ADDR_W:0]   SPAN    = (ADDR_W + 1)'(SPAN_L);
  localparam logic [PB_W-1:0]   PB_C    = PB_W'(PAGE_BYTES);
  localparam logic [FNG_W-1:0]  W_F     = FNG_W'(WINDOW_PAGES);
  localparam logic [PCNT_W-1:0] W_P     = PCNT_W'(WINDOW_PAGES);
  localparam logic [ADDR_W-1:0] W_Q     = ADDR_W'(WINDOW_PAGES);

  // memories
  logic              present_mem [WINDOW_PAGES];
  logic [PCNT_W-1:0] rl_mem      [WINDOW_PAGES];
  logic              present_q;
  logic [PCNT_W-1:0] rl_q;

  // registers
  logic [ADDR_W-1:0]   base_r;
  logic                act_r;
  logic                oow_r;
  logic                flush_r;
  logic [ADDR_W-1:0]   quo_r;
  logic [PCNT_W-1:0]   pages_r;
  logic [FNG_W-1:0]    finger_r;
  logic [FNG_W-1:0]    raddr_r;
  logic [FNG_W-1:0]    dpg_r;
  logic                rd_pend_r;
  logic [FNG_W-1:0]    run_start_r;
  logic [PCNT_W-1:0]   run_cnt_r;
  logic [FNG_W-1:0]    wptr_r;
  logic [PCNT_W-1:0]   mcnt_r;
  logic [ADDR_W-1:0]   off_r;
  res_code_t           code_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_flush_r;

  // combinational
  logic [ADDR_W-1:0]   diff;
  logic                outside;
  logic [ADDR_W-1:0]   dividend;
  logic [PCNT_W-1:0]   pages_sat;
  logic [IDX_W-1:0]    idx;
  logic [PCNT_W-1:0]   room;
  logic [PCNT_W-1:0]   clr_cnt;
  logic [PCNT_W-1:0]   run_end;
  logic                pr_we;
  logic                pr_wd;
  logic                rl_we;
  logic [IDX_W-1:0]    rl_wa;
  logic [PCNT_W-1:0]   rl_wd;

  // unmap window check and page-size shift operand
  assign diff     = in_unmap_address - base_r;
  assign outside  = (in_unmap_address < base_r) || ({1'b0, diff} >= SPAN);
  assign dividend = (in_action == ACT_UNMAP) ? diff
                  : ADDR_W'(in_size_bytes) + ADDR_W'(PAGE_BYTES - 1);

  assign pages_sat = (quo_r == '0) ? PCNT_W'(1)
                   : (quo_r > W_Q) ? W_P + PCNT_W'(1)
                   : PCNT_W'(quo_r);

  assign idx     = quo_r[IDX_W-1:0];
  assign room    = W_P - PCNT_W'(idx);
  assign clr_cnt = (rl_q > room) ? room : rl_q;
  assign run_end = PCNT_W'(run_start_r) + pages_r;

  // memory write selection
  assign pr_we = cmd.mark_step || cmd.clr_step;
  assign pr_wd = cmd.mark_step && (act_r == ACT_MAP);
  assign rl_we = cmd.clr_step || cmd.map_take || cmd.unmap_take;
  assign rl_wa = cmd.map_take ? run_start_r[IDX_W-1:0]
               : cmd.clr_step ? wptr_r[IDX_W-1:0] : idx;
  assign rl_wd = cmd.map_take ? pages_r : '0;

  always_ff @(posedge clk) begin
    if (pr_we) begin
      present_mem[wptr_r[IDX_W-1:0]] <= pr_wd;
    end
    present_q <= present_mem[raddr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rl_we) begin
      rl_mem[rl_wa] <= rl_wd;
    end
    rl_q <= rl_mem[idx];
  end

  // control-like registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      finger_r <= '0;
      wptr_r   <= '0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.retry) begin
        finger_r <= '0;
      end else if (cmd.map_take) begin
        finger_r <= FNG_W'(run_end);
      end
      if (cmd.map_take) begin
        wptr_r <= run_start_r;
      end else if (cmd.unmap_take) begin
        wptr_r <= FNG_W'(idx);
      end else if (cmd.mark_step || cmd.clr_step) begin
        wptr_r <= wptr_r + FNG_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      oow_r   <= outside;
      flush_r <= 1'b0;
      quo_r   <= dividend >> PB_SH;
    end

    if (cmd.scan_init) begin
      pages_r     <= pages_sat;
      raddr_r     <= finger_r;
      run_start_r <= finger_r;
      run_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
    end else if (cmd.retry) begin
      flush_r     <= 1'b1;
      raddr_r     <= '0;
      run_start_r <= '0;
      run_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
    end else if (cmd.scan_run) begin
      if (raddr_r != W_F) begin
        raddr_r   <= raddr_r + FNG_W'(1);
        dpg_r     <= raddr_r;
        rd_pend_r <= 1'b1;
      end else begin
        rd_pend_r <= 1'b0;
      end
      if (rd_pend_r) begin
        if (present_q) begin
          run_start_r <= dpg_r + FNG_W'(1);
          run_cnt_r   <= '0;
        end else begin
          run_cnt_r <= run_cnt_r + PCNT_W'(1);
        end
      end
    end

    if (cmd.map_take) begin
      mcnt_r <= pages_r;
      off_r  <= ADDR_W'(run_start_r * PB_C);
    end else if (cmd.unmap_take) begin
      mcnt_r <= clr_cnt;
    end else if (cmd.mark_step) begin
      mcnt_r <= mcnt_r - PCNT_W'(1);
    end

    if (cmd.set_code) begin
      code_r <= cmd.code;
    end

    if (cmd.res_load) begin
      out_status_r <= code_r;
      out_flush_r  <= flush_r;
      out_addr_r   <= (code_r == RES_OK && act_r == ACT_MAP) ? base_r + off_r : '0;
    end
  end

  assign sts.is_unmap  = (act_r == ACT_UNMAP);
  assign sts.outside   = oow_r;
  assign sts.found     = rd_pend_r && !present_q && (run_cnt_r + PCNT_W'(1) == pages_r);
  assign sts.exhausted = !rd_pend_r && (raddr_r == W_F);
  assign sts.retried   = flush_r;
  assign sts.mark_last = (mcnt_r == PCNT_W'(1));
  assign sts.len_zero  = (rl_q == '0);
  assign sts.clr_last  = (wptr_r == W_F - FNG_W'(1));

  assign out_status      = out_status_r;
  assign out_map_address = out_addr_r;
  assign out_flush_all   = out_flush_r;

  `NFPA_ASSERT_IMP(a_mark_in_window, cmd.mark_step, wptr_r < W_F, "mark past window end")
  `NFPA_ASSERT_IMP(a_found_fits, sts.found, run_end <= W_P, "found run crosses window end")
  `NFPA_ASSERT_IMP(a_finger_bound, cmd.scan_init, finger_r <= W_F, "finger beyond window")

endmodule

// ----- sv/nfpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// nfpa_ctrl
// Sequencer: clear pass, divide, scan with one retry or unmap lookup, mark/clear, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nfpa_pkg::dp_sts_t sts,
  output nfpa_pkg::dp_cmd_t cmd
);
  import nfpa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.is_unmap) begin
          if (sts.outside) begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_OUTSIDE;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_ULOOK;
          end
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.found) begin
          cmd.map_take = 1'b1;
          cmd.set_code = 1'b1;
          cmd.code     = RES_OK;
          state_nxt    = S_MARK;
        end else if (sts.exhausted) begin
          if (!sts.retried) begin
            cmd.retry = 1'b1;
          end else begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_NO_RUN;
            state_nxt    = S_DONE;
          end
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_ULOOK: begin
        cmd.set_code = 1'b1;
        if (sts.len_zero) begin
          cmd.code  = RES_NOT_MAPPED;
          state_nxt = S_DONE;
        end else begin
          cmd.unmap_take = 1'b1;
          cmd.code       = RES_OK;
          state_nxt      = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `NFPA_ASSERT_IMP(a_res_slot_free, cmd.res_load, !out_valid_r || out_ready,
                   "result overwrites an untaken beat")
  `NFPA_ASSERT_NXT(a_clear_once, state_r != S_CLEAR, state_r != S_CLEAR,
                   "clear pass re-entered without reset")
  `NFPA_ASSERT_IMP(a_scan_cmds_excl, sts.found, !sts.exhausted,
                   "scan found a run and ran out at once")

endmodule
